### rtl/bom_pkg.sv
// ----------------------------------------------------------------------------
// bom_pkg: shared types and helpers for the box overlap matcher
// Coordinate and box types, item codes, Q4.12 scaling and box geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package bom_pkg;

  localparam int CoordBits = 16;
  localparam int FieldBits = 16;
  localparam int ScaleBits = 16;
  localparam int ScaleFrac = 12;
  localparam int AreaBits  = 2 * CoordBits;
  localparam int ProdBits  = CoordBits + ScaleBits;

  localparam logic [ScaleBits-1:0] ScaleOne = ScaleBits'(1 << ScaleFrac);

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [AreaBits-1:0]  area_t;
  typedef logic [ScaleBits-1:0] scale_t;
  typedef logic [FieldBits-1:0] field_t;

  typedef struct packed {
    coord_t high_y;
    coord_t right;
    coord_t low_y;
    coord_t left;
  } box_t;

  typedef struct packed {
    logic  hit;
    area_t inter;
  } isect_t;

  typedef enum logic {
    OpTruth = 1'b0,
    OpCand  = 1'b1
  } op_e;

  typedef enum logic {
    RegScaleX = 1'b0,
    RegScaleY = 1'b1
  } cfg_reg_e;

  // truncating Q4.12 scale, saturated to the coordinate range
  function automatic coord_t scale_coord(coord_t c, scale_t s);
    logic [ProdBits-1:0]           p;
    logic [ProdBits-ScaleFrac-1:0] v;
    p = ProdBits'(c) * ProdBits'(s);
    v = p[ProdBits-1:ScaleFrac];
    if (|v[ProdBits-ScaleFrac-1:CoordBits]) begin
      return '1;
    end
    return v[CoordBits-1:0];
  endfunction

  function automatic logic box_empty(box_t b);
    return (b.right <= b.left) || (b.high_y <= b.low_y);
  endfunction

  function automatic area_t box_area(box_t b);
    coord_t dx;
    coord_t dy;
    dx = b.right - b.left;
    dy = b.high_y - b.low_y;
    if (box_empty(b)) begin
      return '0;
    end
    return AreaBits'(dx) * AreaBits'(dy);
  endfunction

endpackage

`default_nettype wire

### rtl/box_overlap_best_match.sv
// ----------------------------------------------------------------------------
// box_overlap_best_match: per-frame best-overlap matcher
// Scales one ground-truth box per frame and keeps the best candidate.
// ----------------------------------------------------------------------------
// One box is taken every cycle unless the intake stalls. An item passes an
// input register, a stage that holds the scaling or intersection multiplier,
// and one that holds the truth-area multiplier and the best-match compare;
// the frame result is registered at the output from that second stage.
// The intake stalls only while a frame result waits at the output and the
// next frame result is ready behind it.
`default_nettype none

module box_overlap_best_match (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_idx_i,
  input  wire  [15:0]           cfg_wdata_i,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // box_left, box_top, box_right, box_bottom
  input  wire  [63:0]           s_axis_tdata_i,
  // op
  input  wire                   s_axis_tuser_i,
  input  wire                   s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  // truth_left, truth_low_y, truth_right, truth_high_y,
  // best_left, best_low_y, best_right, best_high_y
  output logic [127:0]          m_axis_tdata_o,
  // has_truth, found
  output logic [1:0]            m_axis_tuser_o
);
  import bom_pkg::*;

  scale_t scale_x_q, scale_y_q;

  // input register
  logic   in_v_q, in_fe_q;
  op_e    in_op_q;
  box_t   in_cand_q;

  // persistent truth
  box_t   truth_box_q;
  logic   truth_valid_q;
  area_t  truth_area_q;

  // second stage
  logic   s1_v_q, s1_fe_q, s1_tv_q, s1_ok_q;
  op_e    s1_op_q;
  box_t   s1_cand_q, s1_tbox_q;
  area_t  s1_inter_q;

  // best match
  box_t   best_box_q;
  logic   best_valid_q;
  area_t  best_score_q;

  logic         out_v_q;
  logic [1:0]   out_user_q;
  logic [127:0] out_data_q;

  logic   adv;
  box_t   cand_in, scaled, truth_now;
  logic   tv_now;
  isect_t isect;

  logic [AreaBits+3:0] inter10, area3;
  logic   take;
  box_t   best_box_d;
  logic   best_valid_d;
  area_t  best_score_d;
  box_t   out_truth, out_best;

  assign adv = !(s1_v_q && s1_fe_q && out_v_q && !m_axis_tready_i);
  assign s_axis_tready_o = adv;

  always_comb begin
    cand_in.left   = CoordBits'(s_axis_tdata_i[15:0]);
    cand_in.high_y = CoordBits'(s_axis_tdata_i[31:16]);
    cand_in.right  = CoordBits'(s_axis_tdata_i[47:32]);
    cand_in.low_y  = CoordBits'(s_axis_tdata_i[63:48]);
  end

  // scale and swap the edges: in the input low_y holds box_bottom, high_y box_top
  always_comb begin
    scaled.left   = scale_coord(in_cand_q.left,   scale_x_q);
    scaled.low_y  = scale_coord(in_cand_q.high_y, scale_y_q);
    scaled.right  = scale_coord(in_cand_q.right,  scale_x_q);
    scaled.high_y = scale_coord(in_cand_q.low_y,  scale_y_q);
    truth_now     = (in_op_q == OpTruth) ? scaled : truth_box_q;
    tv_now        = (in_op_q == OpTruth) || truth_valid_q;
  end

  bom_isect u_isect (
    .truth_i (truth_box_q),
    .cand_i  (in_cand_q),
    .isect_o (isect)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= ScaleOne;
      scale_y_q <= ScaleOne;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegScaleX: scale_x_q <= cfg_wdata_i;
        RegScaleY: scale_y_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q        <= 1'b0;
      s1_v_q        <= 1'b0;
      truth_valid_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= s_axis_tvalid_i;
      s1_v_q <= in_v_q;
      if (in_v_q) begin
        truth_valid_q <= tv_now && !in_fe_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid_i) begin
      in_op_q   <= op_e'(s_axis_tuser_i);
      in_fe_q   <= s_axis_tlast_i;
      in_cand_q <= cand_in;
    end
    if (adv && in_v_q) begin
      truth_box_q <= truth_now;
      s1_op_q     <= in_op_q;
      s1_fe_q     <= in_fe_q;
      s1_tv_q     <= tv_now;
      s1_tbox_q   <= truth_now;
      s1_cand_q   <= in_cand_q;
      s1_ok_q     <= (in_op_q == OpCand) && truth_valid_q && isect.hit;
      s1_inter_q  <= isect.inter;
    end
    if (adv && s1_v_q && (s1_op_q == OpTruth)) begin
      truth_area_q <= box_area(s1_tbox_q);
    end
  end

  // qualify at 0.3 of the truth area: 10 * inter >= 3 * area
  always_comb begin
    inter10 = (AreaBits+4)'(s1_inter_q) * (AreaBits+4)'(10);
    area3   = (AreaBits+4)'(truth_area_q) * (AreaBits+4)'(3);
    take    = s1_ok_q && (inter10 >= area3) &&
              (!best_valid_q || (s1_inter_q > best_score_q));
    best_box_d   = best_box_q;
    best_valid_d = best_valid_q;
    best_score_d = best_score_q;
    if (s1_op_q == OpTruth) begin
      best_valid_d = 1'b0;
    end else if (take) begin
      best_box_d   = s1_cand_q;
      best_valid_d = 1'b1;
      best_score_d = s1_inter_q;
    end
    out_truth = s1_tv_q ? s1_tbox_q : '0;
    out_best  = best_valid_d ? best_box_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (adv && s1_v_q) begin
        best_valid_q <= best_valid_d && !s1_fe_q;
      end
      if (adv && s1_v_q && s1_fe_q) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      best_box_q   <= best_box_d;
      best_score_q <= best_score_d;
    end
    if (adv && s1_v_q && s1_fe_q) begin
      out_user_q <= {best_valid_d, s1_tv_q};
      out_data_q <= {FieldBits'(out_best.high_y),  FieldBits'(out_best.right),
                     FieldBits'(out_best.low_y),   FieldBits'(out_best.left),
                     FieldBits'(out_truth.high_y), FieldBits'(out_truth.right),
                     FieldBits'(out_truth.low_y),  FieldBits'(out_truth.left)};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tdata_o  = out_data_q;

  a_stall_only_on_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("intake stalled without a blocked result");

  a_best_needs_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_valid_q |-> (truth_area_q != '0))
    else $error("best match held against an empty truth box");

  a_found_needs_truth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tuser_o[0])
    else $error("match reported without a truth box");

  a_no_truth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[63:0] == '0))
    else $error("truth fields not cleared");

endmodule

`default_nettype wire

### rtl/bom_isect.sv
// ----------------------------------------------------------------------------
// bom_isect: candidate against ground-truth intersection
// Touching edges count as overlap; an empty box on either side never hits.
// ----------------------------------------------------------------------------
`default_nettype none

module bom_isect (
  input  bom_pkg::box_t   truth_i,
  input  bom_pkg::box_t   cand_i,
  output bom_pkg::isect_t isect_o
);
  import bom_pkg::*;

  coord_t ix1, ix2, iy1, iy2;
  coord_t dx, dy;
  logic   apart;

  always_comb begin
    ix1   = (truth_i.left   > cand_i.left)   ? truth_i.left   : cand_i.left;
    ix2   = (truth_i.right  < cand_i.right)  ? truth_i.right  : cand_i.right;
    iy1   = (truth_i.low_y  > cand_i.low_y)  ? truth_i.low_y  : cand_i.low_y;
    iy2   = (truth_i.high_y < cand_i.high_y) ? truth_i.high_y : cand_i.high_y;
    dx    = ix2 - ix1;
    dy    = iy2 - iy1;
    apart = (truth_i.left > cand_i.right) || (cand_i.left > truth_i.right) ||
            (truth_i.low_y > cand_i.high_y) || (cand_i.low_y > truth_i.high_y);
    isect_o.hit   = !box_empty(truth_i) && !box_empty(cand_i) && !apart;
    isect_o.inter = AreaBits'(dx) * AreaBits'(dy);
  end

endmodule

`default_nettype wire
